@@ rtl/core/triangle_tangent_frame_core_defines.svh @@
// Assertion macros shared by the tangent frame core.
`ifndef TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH
`define TRIANGLE_TANGENT_FRAME_CORE_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define TTF_CHECK(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tangent frame check failed");

// A condition that implies another in the next cycle.
`define TTF_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tangent frame sequence check failed");

`endif

@@ rtl/core/ttf_pkg.sv @@
package ttf_pkg;

   // Field widths of one input word.
   localparam int POS_WIDTH = 32;
   localparam int UV_WIDTH  = 16;

   // Edge, texture delta, multiplier operand and product widths.
   localparam int E_W  = POS_WIDTH + 1;
   localparam int D_W  = UV_WIDTH + 1;
   localparam int MA_W = (E_W > D_W) ? E_W : D_W;
   localparam int PR_W = MA_W + D_W;
   localparam int V_W  = PR_W + 1;
   localparam int BL_W = $clog2(V_W + 1);
   localparam int VI_W = $clog2(V_W);

   // Normalisation: mantissa, squares, root, numerator and quotient widths.
   localparam int M_W    = 30;
   localparam int FRAC   = 14;
   localparam int OUT_W  = 16;
   localparam int SQ_W   = 2 * M_W + 2;
   localparam int ROOT_W = M_W + 1;
   localparam int N_W    = M_W + FRAC + 1;
   localparam int Q_W    = FRAC + 1;
   localparam int SH_W   = V_W + M_W;

   // Number of words emitted per triangle and the queue depth.
   localparam int COPIES      = 3;
   localparam int QUEUE_DEPTH = 2;

   // One triangle ready for the back end.
   typedef struct packed {
      logic signed [E_W-1:0] e1x;
      logic signed [E_W-1:0] e1y;
      logic signed [E_W-1:0] e1z;
      logic signed [E_W-1:0] e2x;
      logic signed [E_W-1:0] e2y;
      logic signed [E_W-1:0] e2z;
      logic signed [D_W-1:0] du1;
      logic signed [D_W-1:0] dv1;
      logic signed [D_W-1:0] du2;
      logic signed [D_W-1:0] dv2;
   } tri_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

@@ rtl/core/triangle_tangent_frame_core.sv @@
// Channel   Direction  Words                      Handshake
// req_      in         one vertex                 req_valid / req_ready
// rsp_      out        three per closed triangle  rsp_valid / rsp_ready
//
// A vertex is taken whenever req_ready is high; a third vertex waits for room in the two-entry queue.
// The back end takes one triangle at a time; a zero determinant skips straight to the result.
// It pops a triangle, forms the products, then per vector scans for the leading one, scales and
// squares, takes 31 root steps and three divisions, then sends three words, one per cycle while rsp_ready is high.
// Reset is synchronous and clears the phase, the queue and the sequencer.
// A stalled result holds the back end; the front keeps filling the queue.
module triangle_tangent_frame_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0] req_pos_x,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0] req_pos_y,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0] req_pos_z,
   input  logic signed [ttf_pkg::UV_WIDTH-1:0]  req_tex_u,
   input  logic signed [ttf_pkg::UV_WIDTH-1:0]  req_tex_v,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_x,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_y,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_z,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_x,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_y,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_z,
   output logic                                rsp_degenerate,
   output logic                                rsp_last
);

   ttf_pkg::q_status_type q_status;
   ttf_pkg::tri_type      push_data, pop_data;
   logic                  push, pop;

   // Vertex grouping and edge forming.
   ttf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .req_tex_u (req_tex_u),
      .req_tex_v (req_tex_v),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // Triangle queue between the two halves.
   ttf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // Tangent frame arithmetic and result emission.
   ttf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tangent_x   (rsp_tangent_x),
      .rsp_tangent_y   (rsp_tangent_y),
      .rsp_tangent_z   (rsp_tangent_z),
      .rsp_bitangent_x (rsp_bitangent_x),
      .rsp_bitangent_y (rsp_bitangent_y),
      .rsp_bitangent_z (rsp_bitangent_z),
      .rsp_degenerate  (rsp_degenerate),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/core/ttf_front.sv @@
module ttf_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0]  req_pos_x,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0]  req_pos_y,
   input  logic signed [ttf_pkg::POS_WIDTH-1:0]  req_pos_z,
   input  logic signed [ttf_pkg::UV_WIDTH-1:0]   req_tex_u,
   input  logic signed [ttf_pkg::UV_WIDTH-1:0]   req_tex_v,
   input  ttf_pkg::q_status_type                 q_status,
   output logic                                  push,
   output ttf_pkg::tri_type                      push_data
);

   localparam int E_W = ttf_pkg::E_W;
   localparam int D_W = ttf_pkg::D_W;

   logic [1:0] phase_ff;
   logic [1:0] phase_in;
   logic signed [ttf_pkg::POS_WIDTH-1:0] p0_ff [3];
   logic signed [ttf_pkg::POS_WIDTH-1:0] p1_ff [3];
   logic signed [ttf_pkg::UV_WIDTH-1:0]  t0u_ff, t0v_ff, t1u_ff, t1v_ff;
   logic accept;
   logic third;

   // The third vertex needs room in the queue; the first two are always taken.
   assign third     = (phase_ff == 2'd2);
   assign req_ready = !(third && q_status.full);
   assign accept    = req_valid && req_ready;
   assign push      = accept && third;

   // Phase three cannot arise and is treated as phase zero.
   always_comb begin
      case (phase_ff)
         2'd0:    phase_in = 2'd1;
         2'd1:    phase_in = 2'd2;
         2'd2:    phase_in = 2'd0;
         default: phase_in = 2'd1;
      endcase
   end

   // Edges and texture deltas of the triangle closed by this vertex.
   always_comb begin
      push_data.e1x = E_W'(p1_ff[0]) - E_W'(p0_ff[0]);
      push_data.e1y = E_W'(p1_ff[1]) - E_W'(p0_ff[1]);
      push_data.e1z = E_W'(p1_ff[2]) - E_W'(p0_ff[2]);
      push_data.e2x = E_W'(req_pos_x) - E_W'(p0_ff[0]);
      push_data.e2y = E_W'(req_pos_y) - E_W'(p0_ff[1]);
      push_data.e2z = E_W'(req_pos_z) - E_W'(p0_ff[2]);
      push_data.du1 = D_W'(t1u_ff) - D_W'(t0u_ff);
      push_data.dv1 = D_W'(t1v_ff) - D_W'(t0v_ff);
      push_data.du2 = D_W'(req_tex_u) - D_W'(t0u_ff);
      push_data.dv2 = D_W'(req_tex_v) - D_W'(t0v_ff);
   end

   // Phase counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   // Held vertices of the open triangle.
   always_ff @(posedge clock) begin
      if (accept && (phase_ff == 2'd1)) begin
         p1_ff[0] <= req_pos_x;
         p1_ff[1] <= req_pos_y;
         p1_ff[2] <= req_pos_z;
         t1u_ff   <= req_tex_u;
         t1v_ff   <= req_tex_v;
      end else if (accept && !third) begin
         p0_ff[0] <= req_pos_x;
         p0_ff[1] <= req_pos_y;
         p0_ff[2] <= req_pos_z;
         t0u_ff   <= req_tex_u;
         t0v_ff   <= req_tex_v;
      end
   end

endmodule

@@ rtl/core/ttf_queue.sv @@
`include "triangle_tangent_frame_core_defines.svh"

module ttf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ttf_pkg::tri_type       push_data,
   input  logic                   pop,
   output ttf_pkg::tri_type       pop_data,
   output ttf_pkg::q_status_type  q_status
);

   localparam int DEPTH = ttf_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ttf_pkg::tri_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.valid = (count_ff != '0);
   assign pop_data       = slot_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TTF_CHECK(no_push_when_full, !(push && q_status.full))
   `TTF_CHECK(no_pop_when_empty, !(pop && !q_status.valid))
   `TTF_CHECK(count_in_range, count_ff <= CNT_W'(DEPTH))

endmodule

@@ rtl/core/ttf_back.sv @@
`include "triangle_tangent_frame_core_defines.svh"

module ttf_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ttf_pkg::q_status_type               q_status,
   input  ttf_pkg::tri_type                    pop_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_x,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_y,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_tangent_z,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_x,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_y,
   output logic signed [ttf_pkg::OUT_W-1:0]    rsp_bitangent_z,
   output logic                                rsp_degenerate,
   output logic                                rsp_last
);

   localparam int MA_W   = ttf_pkg::MA_W;
   localparam int PR_W   = ttf_pkg::PR_W;
   localparam int V_W    = ttf_pkg::V_W;
   localparam int BL_W   = ttf_pkg::BL_W;
   localparam int VI_W   = ttf_pkg::VI_W;
   localparam int M_W    = ttf_pkg::M_W;
   localparam int FRAC   = ttf_pkg::FRAC;
   localparam int OUT_W  = ttf_pkg::OUT_W;
   localparam int SQ_W   = ttf_pkg::SQ_W;
   localparam int ROOT_W = ttf_pkg::ROOT_W;
   localparam int N_W    = ttf_pkg::N_W;
   localparam int Q_W    = ttf_pkg::Q_W;
   localparam int SH_W   = ttf_pkg::SH_W;
   localparam int J_W    = $clog2(M_W + 1);
   localparam int DC_W   = $clog2(Q_W);
   localparam int LAST_STEP = 13;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_DRAIN, S_SINIT, S_SCAN, S_SHIFT, S_SQ, S_ACC,
      S_ROOT, S_DINIT, S_DIV, S_EMIT
   } state_type;

   state_type state_ff;
   ttf_pkg::tri_type tri_ff;

   // Product pipeline.
   logic [3:0]             step_ff;
   logic [3:0]             lag_step_ff;
   logic                   lag_valid_ff;
   logic signed [PR_W-1:0] prod_ff, first_ff;
   logic signed [MA_W-1:0] mul_a;
   logic signed [ttf_pkg::D_W-1:0] mul_b;
   logic signed [PR_W-1:0] mul_prod;
   logic signed [V_W-1:0]  diff;
   logic signed [V_W-1:0]  det_ff;
   logic signed [V_W-1:0]  tvec_ff [3];
   logic signed [V_W-1:0]  bvec_ff [3];

   // Normalisation.
   logic                   vsel_ff;
   logic [1:0]             comp_ff;
   logic [V_W-1:0]         or_ff;
   logic [BL_W-1:0]        bl_ff;
   logic [M_W-1:0]         m_ff;
   logic [M_W-1:0]         m_arr_ff [3];
   logic                   sgn_ff [3];
   logic [SQ_W-1:0]        sq_ff, sum_ff;
   logic [SQ_W-1:0]        s_ff, r_ff;
   logic [J_W-1:0]         j_ff;
   logic [ROOT_W-1:0]      len_ff;
   logic [ROOT_W-1:0]      rem_ff;
   logic [Q_W-1:0]         lo_ff, q_ff;
   logic [DC_W-1:0]        dcnt_ff;
   logic signed [OUT_W-1:0] tan_ff [3];
   logic signed [OUT_W-1:0] bit_ff [3];
   logic                   degen_ff;
   logic [1:0]             emit_ff;

   logic signed [V_W-1:0]  sel_vec [3];
   logic [V_W-1:0]         sel_mag [3];
   logic signed [V_W-1:0]  cur_vec;
   logic [V_W-1:0]         cur_mag;
   logic [VI_W-1:0]        scan_idx;
   logic [V_W-1:0]         shr;
   logic [SH_W-1:0]        shl;
   logic [M_W-1:0]         m_in;
   logic [SQ_W-1:0]        bitv, rtrial, r_in, s_in;
   logic [N_W-1:0]         num;
   logic [ROOT_W:0]        dtrial;
   logic                   dge;
   logic [Q_W-1:0]         q_in;
   logic signed [OUT_W-1:0] res_in;
   logic                   detneg;

   function automatic logic [V_W-1:0] mag_of(input logic signed [V_W-1:0] v);
      mag_of = v[V_W-1] ? V_W'(-v) : V_W'(v);
   endfunction

   assign detneg = det_ff[V_W-1];
   assign pop    = (state_ff == S_IDLE) && q_status.valid;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff)
         4'd0:    begin mul_a = MA_W'(tri_ff.du1); mul_b = tri_ff.dv2; end
         4'd1:    begin mul_a = MA_W'(tri_ff.du2); mul_b = tri_ff.dv1; end
         4'd2:    begin mul_a = MA_W'(tri_ff.e1x); mul_b = tri_ff.dv2; end
         4'd3:    begin mul_a = MA_W'(tri_ff.e2x); mul_b = tri_ff.dv1; end
         4'd4:    begin mul_a = MA_W'(tri_ff.e1y); mul_b = tri_ff.dv2; end
         4'd5:    begin mul_a = MA_W'(tri_ff.e2y); mul_b = tri_ff.dv1; end
         4'd6:    begin mul_a = MA_W'(tri_ff.e1z); mul_b = tri_ff.dv2; end
         4'd7:    begin mul_a = MA_W'(tri_ff.e2z); mul_b = tri_ff.dv1; end
         4'd8:    begin mul_a = MA_W'(tri_ff.e2x); mul_b = tri_ff.du1; end
         4'd9:    begin mul_a = MA_W'(tri_ff.e1x); mul_b = tri_ff.du2; end
         4'd10:   begin mul_a = MA_W'(tri_ff.e2y); mul_b = tri_ff.du1; end
         4'd11:   begin mul_a = MA_W'(tri_ff.e1y); mul_b = tri_ff.du2; end
         4'd12:   begin mul_a = MA_W'(tri_ff.e2z); mul_b = tri_ff.du1; end
         default: begin mul_a = MA_W'(tri_ff.e1z); mul_b = tri_ff.du2; end
      endcase
   end

   assign mul_prod = PR_W'(mul_a) * PR_W'(mul_b);
   assign diff     = V_W'(first_ff) - V_W'(prod_ff);

   // The vector under normalisation and its current component.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sel_vec[i] = vsel_ff ? bvec_ff[i] : tvec_ff[i];
         sel_mag[i] = mag_of(sel_vec[i]);
      end
   end
   assign cur_vec  = sel_vec[comp_ff];
   assign cur_mag  = sel_mag[comp_ff];
   assign scan_idx = VI_W'(bl_ff - 1'b1);

   // Scale the magnitude so that the largest component lands in [2^29, 2^30).
   assign shr  = cur_mag >> (bl_ff - BL_W'(M_W));
   assign shl  = SH_W'(cur_mag) << (BL_W'(M_W) - bl_ff);
   assign m_in = (bl_ff > BL_W'(M_W)) ? M_W'(shr) : M_W'(shl);

   // One step of the integer square root.
   assign bitv   = SQ_W'(1) << {j_ff, 1'b0};
   assign rtrial = r_ff + bitv;
   always_comb begin
      if (s_ff >= rtrial) begin
         s_in = s_ff - rtrial;
         r_in = (r_ff >> 1) + bitv;
      end else begin
         s_in = s_ff;
         r_in = r_ff >> 1;
      end
   end

   // Rounded numerator and one step of the restoring divider.
   assign num    = N_W'({m_arr_ff[comp_ff], {FRAC{1'b0}}}) + N_W'(len_ff >> 1);
   assign dtrial = {rem_ff, lo_ff[Q_W-1]};
   assign dge    = (dtrial >= {1'b0, len_ff});
   assign q_in   = {q_ff[Q_W-2:0], dge};
   assign res_in = sgn_ff[comp_ff] ? -OUT_W'(q_in) : OUT_W'(q_in);

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lag_valid_ff <= 1'b0;
         emit_ff      <= 2'd0;
         degen_ff     <= 1'b0;
      end else begin
         // Pair up the products as they leave the multiplier.
         if (lag_valid_ff) begin
            if (!lag_step_ff[0]) begin
               first_ff <= prod_ff;
            end else begin
               case (lag_step_ff[3:1])
                  3'd0:    det_ff     <= diff;
                  3'd1:    tvec_ff[0] <= diff;
                  3'd2:    tvec_ff[1] <= diff;
                  3'd3:    tvec_ff[2] <= diff;
                  3'd4:    bvec_ff[0] <= diff;
                  3'd5:    bvec_ff[1] <= diff;
                  default: bvec_ff[2] <= diff;
               endcase
            end
         end

         case (state_ff)
            S_IDLE: begin
               lag_valid_ff <= 1'b0;
               if (q_status.valid) begin
                  tri_ff   <= pop_data;
                  step_ff  <= 4'd0;
                  degen_ff <= 1'b0;
                  vsel_ff  <= 1'b0;
                  emit_ff  <= 2'd0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff      <= mul_prod;
               lag_valid_ff <= 1'b1;
               lag_step_ff  <= step_ff;
               step_ff      <= step_ff + 1'b1;
               if (step_ff == 4'(LAST_STEP)) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               lag_valid_ff <= 1'b0;
               if (det_ff == '0) begin
                  degen_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_SINIT;
               end
            end
            S_SINIT: begin
               or_ff    <= sel_mag[0] | sel_mag[1] | sel_mag[2];
               bl_ff    <= BL_W'(V_W);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // Search down for the leading one of the largest magnitude.
               if (bl_ff == '0) begin
                  degen_ff <= 1'b1;
                  state_ff <= S_EMIT;
               end else if (or_ff[scan_idx]) begin
                  comp_ff  <= 2'd0;
                  sum_ff   <= '0;
                  state_ff <= S_SHIFT;
               end else begin
                  bl_ff <= bl_ff - 1'b1;
               end
            end
            S_SHIFT: begin
               m_ff            <= m_in;
               sgn_ff[comp_ff] <= cur_vec[V_W-1] ^ detneg;
               state_ff        <= S_SQ;
            end
            S_SQ: begin
               m_arr_ff[comp_ff] <= m_ff;
               sq_ff             <= SQ_W'(m_ff) * SQ_W'(m_ff);
               state_ff          <= S_ACC;
            end
            S_ACC: begin
               sum_ff <= sum_ff + sq_ff;
               if (comp_ff == 2'd2) begin
                  s_ff     <= sum_ff + sq_ff;
                  r_ff     <= '0;
                  j_ff     <= J_W'(M_W);
                  state_ff <= S_ROOT;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= S_SHIFT;
               end
            end
            S_ROOT: begin
               s_ff <= s_in;
               r_ff <= r_in;
               j_ff <= j_ff - 1'b1;
               if (j_ff == '0) begin
                  len_ff   <= ROOT_W'(r_in);
                  comp_ff  <= 2'd0;
                  state_ff <= S_DINIT;
               end
            end
            S_DINIT: begin
               rem_ff   <= ROOT_W'(num[N_W-1:Q_W]);
               lo_ff    <= num[Q_W-1:0];
               q_ff     <= '0;
               dcnt_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= dge ? ROOT_W'(dtrial - {1'b0, len_ff}) : ROOT_W'(dtrial);
               lo_ff   <= {lo_ff[Q_W-2:0], 1'b0};
               q_ff    <= q_in;
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DC_W'(Q_W - 1)) begin
                  if (vsel_ff) begin
                     bit_ff[comp_ff] <= res_in;
                  end else begin
                     tan_ff[comp_ff] <= res_in;
                  end
                  if (comp_ff != 2'd2) begin
                     comp_ff  <= comp_ff + 1'b1;
                     state_ff <= S_DINIT;
                  end else if (!vsel_ff) begin
                     vsel_ff  <= 1'b1;
                     state_ff <= S_SINIT;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end
            end
            S_EMIT: begin
               if (rsp_ready) begin
                  if (emit_ff == 2'(ttf_pkg::COPIES - 1)) begin
                     state_ff <= S_IDLE;
                  end else begin
                     emit_ff <= emit_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result word; a degenerate triangle shows zero vectors.
   assign rsp_valid       = (state_ff == S_EMIT);
   assign rsp_last        = (emit_ff == 2'(ttf_pkg::COPIES - 1));
   assign rsp_degenerate  = degen_ff;
   assign rsp_tangent_x   = degen_ff ? '0 : tan_ff[0];
   assign rsp_tangent_y   = degen_ff ? '0 : tan_ff[1];
   assign rsp_tangent_z   = degen_ff ? '0 : tan_ff[2];
   assign rsp_bitangent_x = degen_ff ? '0 : bit_ff[0];
   assign rsp_bitangent_y = degen_ff ? '0 : bit_ff[1];
   assign rsp_bitangent_z = degen_ff ? '0 : bit_ff[2];

   `TTF_CHECK_NEXT(idle_after_last, rsp_valid && rsp_ready && rsp_last, state_ff == S_IDLE)
   `TTF_CHECK(root_length_normalised, (state_ff != S_DINIT) || (len_ff[ROOT_W-1:M_W-1] != '0))
   `TTF_CHECK(emit_count_in_range, emit_ff != 2'd3)

endmodule
